@@ rtl/ftl_pkg.sv @@
package ftl_pkg;

    localparam logic OP_CLIENT = 1'b0;
    localparam logic OP_REPLY  = 1'b1;

    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_FREE    = 2'd1,
        ST_EVICT   = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_status;

    typedef struct packed {
        logic        op;
        logic [15:0] src_family;
        logic [15:0] src_port;
        logic [31:0] src_ip;
        logic [15:0] handle;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [2:0]  slot;
        logic [15:0] evicted_handle;
        logic [15:0] entry_handle;
        logic [15:0] peer_family;
        logic [15:0] peer_port;
        logic [31:0] peer_ip;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic lookup;
        logic scan_step;
        logic commit;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } t_stat;

endpackage

@@ rtl/ftl_stream_if.sv @@
interface ftl_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/ftl_ctrl.sv @@
module ftl_ctrl import ftl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_SCAN   = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = i_stat.need_scan ? S_SCAN : S_COMMIT;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // result register must be free before the table is touched
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // no beat is taken while reset is held
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("result beat not raised after commit");

endmodule

@@ rtl/ftl_dp.sv @@
module ftl_dp import ftl_pkg::*; #(
    parameter int ENTRIES = 8
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_req  i_req_data,
    output t_stat o_stat,
    output t_rsp  o_rsp_data
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // table, one register set per slot
    logic [63:0]  r_stamp [ENTRIES];
    logic [15:0]  r_fam   [ENTRIES];
    logic [15:0]  r_port  [ENTRIES];
    logic [31:0]  r_ip    [ENTRIES];
    logic [15:0]  r_hdl   [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [63:0]  r_cnt;
    logic [CW-1:0] r_used;

    t_req         r_req;
    t_status      r_status;
    logic [IW-1:0] r_sel;
    logic [IW-1:0] r_scan;
    logic          r_best_ok;
    logic [IW-1:0] r_best_idx;
    logic [63:0]   r_best_stamp;
    t_rsp          r_rsp;

    logic [ENTRIES-1:0] w_match, w_free;
    logic [IW-1:0]      w_hit_idx, w_free_idx, w_sel;
    logic               w_hit, w_free_ok, w_fill, w_take;
    logic [63:0]        w_next_cnt;
    t_status            w_status;
    t_rsp               w_rsp;

    // parallel compare against every slot
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (r_req.op == OP_REPLY) begin
                w_match[i] = r_valid[i] && (r_hdl[i] == r_req.handle);
            end else begin
                w_match[i] = r_valid[i] && (r_fam[i] == r_req.src_family)
                           && (r_port[i] == r_req.src_port) && (r_ip[i] == r_req.src_ip);
            end
            w_free[i] = !r_valid[i];
        end
    end

    // lowest index wins
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_hit_idx = IW'(i);
            end
            if (w_free[i]) begin
                w_free_idx = IW'(i);
            end
        end
    end

    assign w_hit     = |w_match;
    assign w_free_ok = (|w_free) && (r_used < CW'(ENTRIES));

    always_comb begin
        if (w_hit) begin
            w_status = ST_HIT;
        end else if (r_req.op == OP_REPLY) begin
            w_status = ST_UNKNOWN;
        end else if (w_free_ok) begin
            w_status = ST_FREE;
        end else begin
            w_status = ST_EVICT;
        end
    end

    assign o_stat.need_scan = (w_status == ST_EVICT);
    assign o_stat.scan_last = (r_scan == IW'(ENTRIES - 1));

    // oldest valid stamp, one slot per cycle
    assign w_take = r_valid[r_scan] && (!r_best_ok || (r_stamp[r_scan] < r_best_stamp));

    assign w_sel  = (r_status == ST_EVICT) ? r_best_idx : r_sel;
    assign w_fill = (r_status == ST_FREE) || (r_status == ST_EVICT);

    always_comb begin
        w_next_cnt = r_cnt + 64'd1;
        if (w_next_cnt == 64'd0) begin
            w_next_cnt = 64'd1;  // stamp skips zero; slot validity is kept in r_valid
        end
    end

    always_comb begin
        w_rsp = '0;
        if (r_status != ST_UNKNOWN) begin
            w_rsp.status = r_status;
            w_rsp.slot   = 3'(w_sel);
            if (r_status == ST_EVICT) begin
                w_rsp.evicted_handle = r_hdl[w_sel];
            end
            if (w_fill) begin
                w_rsp.entry_handle = r_req.handle;
                w_rsp.peer_family  = r_req.src_family;
                w_rsp.peer_port    = r_req.src_port;
                w_rsp.peer_ip      = r_req.src_ip;
            end else begin
                w_rsp.entry_handle = r_hdl[w_sel];
                w_rsp.peer_family  = r_fam[w_sel];
                w_rsp.peer_port    = r_port[w_sel];
                w_rsp.peer_ip      = r_ip[w_sel];
            end
        end else begin
            w_rsp.status = ST_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_cnt     <= '0;
            r_used    <= '0;
            r_scan    <= '0;
            r_best_ok <= 1'b0;
        end else begin
            if (i_cmd.lookup) begin
                r_scan    <= '0;
                r_best_ok <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_scan <= r_scan + IW'(1);
                if (w_take) begin
                    r_best_ok <= 1'b1;
                end
            end
            if (i_cmd.commit && (r_status != ST_UNKNOWN)) begin
                r_valid[w_sel] <= 1'b1;
                r_cnt          <= w_next_cnt;
                if (r_status == ST_FREE) begin
                    r_used <= r_used + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req_data;
        end
        if (i_cmd.lookup) begin
            r_status   <= w_status;
            r_sel      <= w_hit ? w_hit_idx : w_free_idx;
            r_best_idx <= '0;
        end
        if (i_cmd.scan_step && w_take) begin
            r_best_idx   <= r_scan;
            r_best_stamp <= r_stamp[r_scan];
        end
        if (i_cmd.commit) begin
            r_rsp <= w_rsp;
            if (r_status != ST_UNKNOWN) begin
                r_stamp[w_sel] <= w_next_cnt;
                if (w_fill) begin
                    r_fam[w_sel]  <= r_req.src_family;
                    r_port[w_sel] <= r_req.src_port;
                    r_ip[w_sel]   <= r_req.src_ip;
                    r_hdl[w_sel]  <= r_req.handle;
                end
            end
        end
    end

    assign o_rsp_data = r_rsp;

    a_cnt_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_status != ST_UNKNOWN)) |=> (r_cnt != 64'd0))
        else $error("access counter reads zero after a refresh");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(ENTRIES))
        else $error("fill count above table size");

    a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_status == ST_FREE)) |-> !r_valid[r_sel])
        else $error("free fill targets a valid slot");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && (r_status == ST_EVICT)) |-> (r_used == CW'(ENTRIES)))
        else $error("eviction while table not full");

endmodule

@@ rtl/flow_table_lru.sv @@
// Session table with least-recently-used replacement.
//
// i_req (sink): one beat per packet. op 0 looks the client source key up and
// fills or evicts on a miss; op 1 looks a session handle up and returns the
// stored client key. o_rsp (source): exactly one result beat per request.
//
// Timing: a request is taken in idle, compared against all slots in the next
// cycle, then written back and registered for output in commit state once
// the result register is free, for hits, free fills and unknown handles. An
// eviction first runs the scan state: a one-slot-per-cycle scan for the
// oldest stamp. The result appears on o_rsp the cycle after write-back.
// One item is in flight at a time; i_req.ready is high only in idle.
//
// Reset (synchronous, active low) empties the table and clears the access
// counter at once; no clearing pass. If o_rsp is stalled, the next request
// is still taken and looked up, and its write-back waits until the pending
// result beat has gone.
module flow_table_lru import ftl_pkg::*; #(
    parameter int ENTRIES = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ftl_stream_if.sink   i_req,
    ftl_stream_if.source o_rsp
);

    t_cmd  w_cmd;
    t_stat w_stat;
    t_rsp  w_rsp;
    t_req  w_req;

    assign w_req = i_req.data;

    ftl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ftl_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_req_data (w_req),
        .o_stat     (w_stat),
        .o_rsp_data (w_rsp)
    );

    assign o_rsp.data = w_rsp;

endmodule

@@ tb/sv/flow_table_lru_test.sv @@
module flow_table_lru_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ftl_pkg::*;

    localparam int ENTRIES     = 8;
    localparam int RAND_ITEMS  = 850;
    localparam int KEY_POOL    = 12;
    localparam int CALM_ITEMS  = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int IDLE_LIMIT  = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ftl_stream_if #(.T(t_req)) req_if ();
    ftl_stream_if #(.T(t_rsp)) rsp_if ();

    flow_table_lru #(
        .ENTRIES (ENTRIES)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow copy of the session table
    logic [63:0] tbl_stamp  [ENTRIES];
    logic [15:0] tbl_family [ENTRIES];
    logic [15:0] tbl_port   [ENTRIES];
    logic [31:0] tbl_ip     [ENTRIES];
    logic [15:0] tbl_handle [ENTRIES];
    logic [63:0] access_count;
    int          tbl_used;

    t_req pkt_queue[$];
    t_rsp lookup_results_q[$];

    int n_total;
    int n_sent;
    int n_seen;
    int err_count;
    int idle_cycles;

    function automatic t_rsp table_access(t_req r);
        t_rsp res;
        int   sel;
        int   oldest;
        res = '0;
        sel = -1;
        if (r.op == OP_CLIENT) begin
            for (int i = 0; i < ENTRIES; i++)
                if (sel < 0 && tbl_stamp[i] != 0 && tbl_family[i] == r.src_family &&
                    tbl_port[i] == r.src_port && tbl_ip[i] == r.src_ip)
                    sel = i;
            if (sel >= 0) begin
                res.status = ST_HIT;
            end else begin
                if (tbl_used < ENTRIES)
                    for (int i = 0; i < ENTRIES; i++)
                        if (sel < 0 && tbl_stamp[i] == 0)
                            sel = i;
                if (sel >= 0) begin
                    res.status = ST_FREE;
                    tbl_used++;
                end else begin
                    oldest = -1;
                    for (int i = 0; i < ENTRIES; i++)
                        if (tbl_stamp[i] != 0 &&
                            (oldest < 0 || tbl_stamp[i] < tbl_stamp[oldest]))
                            oldest = i;
                    sel = (oldest < 0) ? 0 : oldest;
                    res.status = ST_EVICT;
                    res.evicted_handle = tbl_handle[sel];
                end
                tbl_family[sel] = r.src_family;
                tbl_port[sel]   = r.src_port;
                tbl_ip[sel]     = r.src_ip;
                tbl_handle[sel] = r.handle;
            end
        end else begin
            for (int i = 0; i < ENTRIES; i++)
                if (sel < 0 && tbl_stamp[i] != 0 && tbl_handle[i] == r.handle)
                    sel = i;
            if (sel < 0) begin
                res.status = ST_UNKNOWN;
                return res;
            end
            res.status = ST_HIT;
        end
        // counter skips zero so a live slot never looks empty
        access_count = access_count + 64'd1;
        if (access_count == 64'd0)
            access_count = 64'd1;
        tbl_stamp[sel]   = access_count;
        res.slot         = sel[2:0];
        res.entry_handle = tbl_handle[sel];
        res.peer_family  = tbl_family[sel];
        res.peer_port    = tbl_port[sel];
        res.peer_ip      = tbl_ip[sel];
        return res;
    endfunction

    function automatic void add_pkt(logic op, logic [15:0] fam, logic [15:0] port,
                                    logic [31:0] ip, logic [15:0] hdl);
        t_req r;
        r.op         = op;
        r.src_family = fam;
        r.src_port   = port;
        r.src_ip     = ip;
        r.handle     = hdl;
        pkt_queue.push_back(r);
    endfunction

    task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: beat %0d %s mismatch: expected %h, actual %h",
                     $time, n_seen, what, want, got);
            err_count++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin : drive
        int gap_left;
        int idle_pct;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            gap_left = 0;
            idle_pct = 10;
        end else begin
            if (req_if.valid && req_if.ready) begin
                lookup_results_q.push_back(table_access(req_if.data));
                void'(pkt_queue.pop_front());
                n_sent++;
                if (n_sent % 64 == 0)
                    case ($urandom_range(0, 2))
                        0: idle_pct = 0;
                        1: idle_pct = 10;
                        default: idle_pct = 35;
                    endcase
            end
            if (!(req_if.valid && !req_if.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    req_if.valid <= 1'b0;
                end else if (pkt_queue.size() == 0) begin
                    req_if.valid <= 1'b0;
                end else if (n_sent < n_total - CALM_ITEMS &&
                             $urandom_range(0, 99) < idle_pct) begin
                    gap_left = $urandom_range(1, 6) - 1;
                    req_if.valid <= 1'b0;
                end else begin
                    req_if.valid <= 1'b1;
                    req_if.data  <= pkt_queue[0];
                end
            end
        end
    end

    // result monitor and ready generation
    always @(posedge i_clk) begin : monitor
        t_rsp want;
        t_rsp got;
        int   stall_left;
        int   hold_left;
        int   stall_pct;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            stall_pct  = 10;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (lookup_results_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected: expected none, actual %h",
                             $time, got);
                    err_count++;
                end else begin
                    want = lookup_results_q.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("slot", 32'(want.slot), 32'(got.slot));
                    check_field("evicted_handle", 32'(want.evicted_handle),
                                32'(got.evicted_handle));
                    check_field("entry_handle", 32'(want.entry_handle),
                                32'(got.entry_handle));
                    check_field("peer_family", 32'(want.peer_family), 32'(got.peer_family));
                    check_field("peer_port", 32'(want.peer_port), 32'(got.peer_port));
                    check_field("peer_ip", want.peer_ip, got.peer_ip);
                end
                n_seen++;
                // long back-pressure so the request side stalls
                if (n_seen == 120 || n_seen == 500)
                    hold_left = HOLD_CYCLES;
                if (n_seen % 64 == 0)
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 10;
                        default: stall_pct = 35;
                    endcase
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (n_seen < n_total - CALM_ITEMS &&
                         $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 6) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] pool_fam [KEY_POOL];
        logic [15:0] pool_port[KEY_POOL];
        logic [31:0] pool_ip  [KEY_POOL];
        logic [15:0] pool_hdl [KEY_POOL];
        logic [63:0] key;
        int          pick;
        int          k;

        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        n_sent       = 0;
        n_seen       = 0;
        err_count    = 0;
        idle_cycles  = 0;
        access_count = '0;
        tbl_used     = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_stamp[i]  = '0;
            tbl_family[i] = '0;
            tbl_port[i]   = '0;
            tbl_ip[i]     = '0;
            tbl_handle[i] = '0;
        end

        // empty table: handle 0 matches the zeroed shadow entries but none is live
        add_pkt(OP_REPLY, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000);
        add_pkt(OP_CLIENT, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000);
        add_pkt(OP_CLIENT, 16'hffff, 16'hffff, 32'hffff_ffff, 16'hffff);
        // hit ignores the new handle
        add_pkt(OP_CLIENT, 16'h0000, 16'h0000, 32'h0000_0000, 16'h1234);
        add_pkt(OP_REPLY, 16'h0000, 16'h0000, 32'h0000_0000, 16'hffff);
        add_pkt(OP_REPLY, 16'hffff, 16'hffff, 32'hffff_ffff, 16'h0000);
        // fill the rest, two slots share a handle
        add_pkt(OP_CLIENT, 16'h0002, 16'h0035, 32'hc0a8_0001, 16'h5555);
        add_pkt(OP_CLIENT, 16'h0002, 16'h0035, 32'hc0a8_0002, 16'h5555);
        add_pkt(OP_CLIENT, 16'h000a, 16'h1f90, 32'h0a00_0001, 16'h0101);
        add_pkt(OP_CLIENT, 16'h8000, 16'h8000, 32'h8000_0000, 16'haaaa);
        add_pkt(OP_CLIENT, 16'h0001, 16'h0001, 32'h0000_0001, 16'h7fff);
        add_pkt(OP_CLIENT, 16'h7fff, 16'h7fff, 32'h7fff_ffff, 16'h8000);
        add_pkt(OP_REPLY, 16'h0000, 16'h0000, 32'h0000_0000, 16'h5555);
        // full table: misses evict the oldest
        add_pkt(OP_CLIENT, 16'h0002, 16'h0036, 32'hc0a8_0001, 16'hbeef);
        add_pkt(OP_REPLY, 16'h0000, 16'h0000, 32'h0000_0000, 16'hffff);
        add_pkt(OP_CLIENT, 16'hfffe, 16'hffff, 32'hffff_ffff, 16'hcafe);
        add_pkt(OP_REPLY, 16'h1234, 16'h5678, 32'h9abc_def0, 16'h5555);
        add_pkt(OP_REPLY, 16'hffff, 16'hffff, 32'hffff_ffff, 16'habcd);
        // key differs in one bit of the address only
        add_pkt(OP_CLIENT, 16'h0002, 16'h0035, 32'hc0a8_0003, 16'h0000);
        add_pkt(OP_CLIENT, 16'h000a, 16'h1f90, 32'h0a00_0001, 16'hffff);
        add_pkt(OP_REPLY, 16'h0000, 16'h0000, 32'h0000_0000, 16'hbeef);
        add_pkt(OP_CLIENT, 16'h0002, 16'h0035, 32'hc0a8_0002, 16'h0001);

        for (int i = 0; i < KEY_POOL; i++) begin
            pool_fam[i]  = 16'($urandom);
            pool_port[i] = 16'($urandom);
            pool_ip[i]   = $urandom;
            pool_hdl[i]  = 16'($urandom);
        end
        pool_hdl[KEY_POOL-1] = pool_hdl[KEY_POOL-2];

        // more keys than slots, so hits and evictions both recur
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 150 == 149) begin
                k = $urandom_range(0, KEY_POOL - 1);
                pool_fam[k]  = 16'($urandom);
                pool_port[k] = 16'($urandom);
                pool_ip[k]   = $urandom;
                pool_hdl[k]  = 16'($urandom);
            end
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, KEY_POOL - 1);
            if (pick < 45) begin
                add_pkt(OP_CLIENT, pool_fam[k], pool_port[k], pool_ip[k],
                        ($urandom_range(0, 3) == 0) ? 16'($urandom) : pool_hdl[k]);
            end else if (pick < 75) begin
                add_pkt(OP_REPLY, 16'($urandom), 16'($urandom), $urandom, pool_hdl[k]);
            end else if (pick < 85) begin
                key = {pool_fam[k], pool_port[k], pool_ip[k]};
                key[$urandom_range(0, 63)] ^= 1'b1;
                add_pkt(OP_CLIENT, key[63:48], key[47:32], key[31:0], 16'($urandom));
            end else begin
                add_pkt(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom), $urandom,
                        16'($urandom));
            end
        end
        n_total = pkt_queue.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (n_sent < n_total || lookup_results_q.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (lookup_results_q.size() != 0) begin
            $display("%0t: results still pending: expected 0, actual %0d",
                     $time, lookup_results_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ftl_pkg.sv
rtl/ftl_stream_if.sv
rtl/ftl_ctrl.sv
rtl/ftl_dp.sv
rtl/flow_table_lru.sv
tb/sv/flow_table_lru_test.sv
